// ===== design/nfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfpa_pkg - noise floor power average shared definitions
// Widths, lane count and the Q39 power table 10^(-k/10).
// ----------------------------------------------------------------------------
package nfpa_pkg;

  localparam int NUM_LANES = 4;
  localparam int TBL_SIZE  = 111;
  localparam int MAX_IDX   = TBL_SIZE - 1;
  localparam int PWR_W     = 39;
  localparam int SUM_W     = PWR_W + 2;
  localparam int IDX_W     = 7;
  localparam int NUM_THR   = TBL_SIZE - 1;
  localparam int GRP_SZ    = 11;
  localparam int NUM_GRP   = NUM_THR / GRP_SZ;
  localparam int CNT_W     = 4;

  typedef logic [PWR_W-1:0] pwr_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic load_mean;
    logic load_thr;
    logic load_cnt;
    logic load_out;
  } pipe_ctl_t;

  function automatic pwr_t pow_lut(input idx_t k);
    pwr_t p;
    case (k)
      7'd0:   p = 39'h7FFFFFFFFF;
      7'd1:   p = 39'h65AC8C2F36;
      7'd2:   p = 39'h50C335D3DB;
      7'd3:   p = 39'h4026E73CCD;
      7'd4:   p = 39'h32F52CFEEA;
      7'd5:   p = 39'h287A26C490;
      7'd6:   p = 39'h2026F30FBB;
      7'd7:   p = 39'h198A13577C;
      7'd8:   p = 39'h144960C577;
      7'd9:   p = 39'h101D3F2D96;
      7'd10:  p = 39'h0CCCCCCCCD;
      7'd11:  p = 39'h0A2ADAD185;
      7'd12:  p = 39'h08138561FC;
      7'd13:  p = 39'h066A4A52E1;
      7'd14:  p = 39'h0518847FE4;
      7'd15:  p = 39'h040C3713A8;
      7'd16:  p = 39'h0337184E5F;
      7'd17:  p = 39'h028DCEBBF3;
      7'd18:  p = 39'h0207567A25;
      7'd19:  p = 39'h019C86515C;
      7'd20:  p = 39'h0147AE147B;
      7'd21:  p = 39'h01044914F4;
      7'd22:  p = 39'h00CEC089CC;
      7'd23:  p = 39'h00A43AA1E3;
      7'd24:  p = 39'h008273A664;
      7'd25:  p = 39'h00679F1B91;
      7'd26:  p = 39'h00524F3B0A;
      7'd27:  p = 39'h0041617932;
      7'd28:  p = 39'h0033EF0C37;
      7'd29:  p = 39'h002940A1BC;
      7'd30:  p = 39'h0020C49BA6;
      7'd31:  p = 39'h001A074EE5;
      7'd32:  p = 39'h0014ACDA94;
      7'd33:  p = 39'h00106C4364;
      7'd34:  p = 39'h000D0B90A4;
      7'd35:  p = 39'h000A5CB5F5;
      7'd36:  p = 39'h00083B1F81;
      7'd37:  p = 39'h000689BF52;
      7'd38:  p = 39'h0005318139;
      7'd39:  p = 39'h000420102C;
      7'd40:  p = 39'h000346DC5D;
      7'd41:  p = 39'h00029A54B1;
      7'd42:  p = 39'h000211490F;
      7'd43:  p = 39'h0001A46D24;
      7'd44:  p = 39'h00014DF4DD;
      7'd45:  p = 39'h0001094565;
      7'd46:  p = 39'h0000D2B65A;
      7'd47:  p = 39'h0000A75FEF;
      7'd48:  p = 39'h000084F352;
      7'd49:  p = 39'h0000699B38;
      7'd50:  p = 39'h000053E2D6;
      7'd51:  p = 39'h000042A212;
      7'd52:  p = 39'h000034EDB5;
      7'd53:  p = 39'h00002A0AEA;
      7'd54:  p = 39'h0000216549;
      7'd55:  p = 39'h00001A86F1;
      7'd56:  p = 39'h000015123C;
      7'd57:  p = 39'h000010BCCB;
      7'd58:  p = 39'h00000D4B88;
      7'd59:  p = 39'h00000A8F86;
      7'd60:  p = 39'h000008637C;
      7'd61:  p = 39'h000006A9CF;
      7'd62:  p = 39'h0000054AF8;
      7'd63:  p = 39'h000004344B;
      7'd64:  p = 39'h00000356EE;
      7'd65:  p = 39'h000002A718;
      7'd66:  p = 39'h0000021B6C;
      7'd67:  p = 39'h000001AC7B;
      7'd68:  p = 39'h000001545A;
      7'd69:  p = 39'h0000010E5A;
      7'd70:  p = 39'h000000D6C0;
      7'd71:  p = 39'h000000AA95;
      7'd72:  p = 39'h000000877F;
      7'd73:  p = 39'h0000006BA1;
      7'd74:  p = 39'h000000557E;
      7'd75:  p = 39'h00000043E9;
      7'd76:  p = 39'h00000035F1;
      7'd77:  p = 39'h0000002AD9;
      7'd78:  p = 39'h0000002209;
      7'd79:  p = 39'h0000001B09;
      7'd80:  p = 39'h000000157A;
      7'd81:  p = 39'h000000110F;
      7'd82:  p = 39'h0000000D8D;
      7'd83:  p = 39'h0000000AC3;
      7'd84:  p = 39'h000000088D;
      7'd85:  p = 39'h00000006CA;
      7'd86:  p = 39'h0000000565;
      7'd87:  p = 39'h0000000449;
      7'd88:  p = 39'h0000000367;
      7'd89:  p = 39'h00000002B4;
      7'd90:  p = 39'h0000000226;
      7'd91:  p = 39'h00000001B5;
      7'd92:  p = 39'h000000015B;
      7'd93:  p = 39'h0000000114;
      7'd94:  p = 39'h00000000DB;
      7'd95:  p = 39'h00000000AE;
      7'd96:  p = 39'h000000008A;
      7'd97:  p = 39'h000000006E;
      7'd98:  p = 39'h0000000057;
      7'd99:  p = 39'h0000000045;
      7'd100: p = 39'h0000000037;
      7'd101: p = 39'h000000002C;
      7'd102: p = 39'h0000000023;
      7'd103: p = 39'h000000001C;
      7'd104: p = 39'h0000000016;
      7'd105: p = 39'h0000000011;
      7'd106: p = 39'h000000000E;
      7'd107: p = 39'h000000000B;
      7'd108: p = 39'h0000000009;
      7'd109: p = 39'h0000000007;
      7'd110: p = 39'h0000000005;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Midpoint boundary between entries k and k+1, kept at twice scale.
  function automatic logic [PWR_W:0] thr_sum(input idx_t k);
    return {1'b0, pow_lut(k)} + {1'b0, pow_lut(k + idx_t'(1))};
  endfunction

endpackage

// ===== design/nfpa_lane.sv =====
// ----------------------------------------------------------------------------
// nfpa_lane - per-antenna dBm to linear power
// Magnitude of the signed level, clamp to the last table index, table lookup.
// ----------------------------------------------------------------------------
module nfpa_lane (
  input  logic               clk,
  input  logic               load,
  input  logic signed [7:0]  noise,
  output nfpa_pkg::pwr_t     pwr
);
  import nfpa_pkg::*;

  logic [7:0] mag;
  idx_t       idx;

  always_comb begin
    mag = noise[7] ? (8'd0 - noise) : noise;
    idx = (mag > 8'(MAX_IDX)) ? idx_t'(MAX_IDX) : mag[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pwr <= pow_lut(idx);
    end
  end

endmodule

// ===== design/nfpa_merge.sv =====
// ----------------------------------------------------------------------------
// nfpa_merge - lane power combiner and nearest-entry search
// Sum and mean, boundary compares to a thermometer code, grouped count, index.
// ----------------------------------------------------------------------------
module nfpa_merge (
  input  logic                  clk,
  input  nfpa_pkg::pipe_ctl_t   ctl,
  input  nfpa_pkg::pwr_t        pwr [nfpa_pkg::NUM_LANES],
  output logic signed [7:0]     noise_floor_dbm
);
  import nfpa_pkg::*;

  logic [SUM_W-1:0] sum;
  pwr_t             mean;
  logic [NUM_THR-1:0] therm;
  cnt_t             grp_cnt [NUM_GRP];
  cnt_t             grp_cnt_next [NUM_GRP];
  idx_t             total;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum = sum + SUM_W'(pwr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_mean) begin
      mean <= sum[SUM_W-1:2];
    end
  end

  // Closer to entry k+1 (tie included) when 2*mean <= t[k] + t[k+1].
  always_ff @(posedge clk) begin
    if (ctl.load_thr) begin
      for (int k = 0; k < NUM_THR; k++) begin
        therm[k] <= ({mean, 1'b0} <= thr_sum(idx_t'(k)));
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_cnt_next[g] = '0;
      for (int b = 0; b < GRP_SZ; b++) begin
        grp_cnt_next[g] = grp_cnt_next[g] + cnt_t'(therm[g*GRP_SZ + b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_cnt) begin
      grp_cnt <= grp_cnt_next;
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      total = total + idx_t'(grp_cnt[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      noise_floor_dbm <= 8'd0 - {1'b0, total};
    end
  end

endmodule

// ===== design/noise_floor_power_average_unit.sv =====
// ----------------------------------------------------------------------------
// noise_floor_power_average_unit - four-antenna noise floor combiner
// Throughput: one beat per cycle while out_stall is low; five-stage pipeline, one result per beat.
// A stage loads whenever it is empty or the stage after it moves on.
// Reset (rst, synchronous) empties the pipeline; payload registers are not reset.
// ----------------------------------------------------------------------------
module noise_floor_power_average_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] noise_ant0,
  input  logic signed [7:0] noise_ant1,
  input  logic signed [7:0] noise_ant2,
  input  logic signed [7:0] noise_ant3,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] noise_floor_dbm
);
  import nfpa_pkg::*;

  logic      v1, v2, v3, v4;
  logic      rdy1, rdy2, rdy3, rdy4, rdy5;
  logic      load_pwr;
  pipe_ctl_t ctl;
  pwr_t      pwr [NUM_LANES];
  logic signed [7:0] noise [NUM_LANES];

  assign noise[0] = noise_ant0;
  assign noise[1] = noise_ant1;
  assign noise[2] = noise_ant2;
  assign noise[3] = noise_ant3;

  always_comb begin
    rdy5 = !out_valid || !out_stall;
    rdy4 = !v4 || rdy5;
    rdy3 = !v3 || rdy4;
    rdy2 = !v2 || rdy3;
    rdy1 = !v1 || rdy2;
    in_stall = !rdy1;
    load_pwr = in_valid && rdy1;
    ctl.load_mean = v1 && rdy2;
    ctl.load_thr  = v2 && rdy3;
    ctl.load_cnt  = v3 && rdy4;
    ctl.load_out  = v4 && rdy5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    nfpa_lane u_lane (
      .clk   (clk),
      .load  (load_pwr),
      .noise (noise[i]),
      .pwr   (pwr[i])
    );
  end

  nfpa_merge u_merge (
    .clk             (clk),
    .ctl             (ctl),
    .pwr             (pwr),
    .noise_floor_dbm (noise_floor_dbm)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && out_valid && out_stall))
    else $error("input stalled while pipeline has room");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted beat lost at lane stage");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(noise_floor_dbm) <= 8'sd0 && $signed(noise_floor_dbm) >= -8'sd110))
    else $error("noise floor out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !v4) |=> !out_valid)
    else $error("output beat repeated");

endmodule
